@@ src/ffba_pkg.sv @@
// Shared types, codes and a helper function for the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int OFF_W = 16;
    localparam int LEN_W = 17;
    localparam int BS_W  = 19;
    localparam int LOG_W = 5;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_SHRINK = 2'd2;
    localparam logic [OP_W-1:0] OP_MERGE  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_GROW   = 2'd3;

    localparam logic [2:0] WS_INIT   = 3'd0;
    localparam logic [2:0] WS_ALLOC  = 3'd1;
    localparam logic [2:0] WS_RD     = 3'd2;
    localparam logic [2:0] WS_APPEND = 3'd3;
    localparam logic [2:0] WS_KEY    = 3'd4;
    localparam logic [2:0] WS_CUR    = 3'd5;

    typedef struct packed {
        logic            we;
        logic [2:0]      wsel;
        logic            cfg_load;
        logic            init_wr;
        logic            load_item;
        logic            alloc_take;
        logic            append;
        logic            key_load;
        logic            cur_load;
        logic            cur_join;
        logic            status_wr;
        logic [ST_W-1:0] status_val;
        logic            out_load;
    } ffba_cmd_t;

    typedef struct packed {
        logic            fit;
        logic            empties;
        logic            key_gt;
        logic            adj;
        logic            free_zero;
        logic            shr_grow;
        logic            shr_append;
        logic [OP_W-1:0] op;
    } ffba_sts_t;

    // Smallest power of two not below v (one for zero).
    function automatic logic [BS_W-1:0] round_pow2(input logic [BS_W-1:0] v);
        logic [BS_W-1:0] x;
        begin
            x = v - BS_W'(1);
            x = x | (x >> 1);
            x = x | (x >> 2);
            x = x | (x >> 4);
            x = x | (x >> 8);
            x = x | (x >> 16);
            round_pow2 = (v <= BS_W'(1)) ? BS_W'(1) : x + BS_W'(1);
        end
    endfunction

endpackage

@@ src/ffba_dp.sv @@
// Datapath of the allocator: free table memory, working registers and result registers.
`timescale 1ns / 1ps
module ffba_dp import ffba_pkg::*; #(
    parameter int MAX_FREE_BLOCKS = 64,
    parameter int HEADER_BYTES    = 32,
    parameter int MAX_HEAP_LOG2   = 16,
    localparam int IDX_W = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffba_cmd_t         cmd,
    output ffba_sts_t         sts,
    input  logic [IDX_W-1:0]  rd_addr,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [LOG_W-1:0]  cfg_wdata,
    input  logic [OP_W-1:0]   s_opcode,
    input  logic [LEN_W-1:0]  s_req_size,
    input  logic [OFF_W-1:0]  s_block_offset,
    input  logic [LEN_W-1:0]  s_block_bytes,
    output logic [ST_W-1:0]   m_status,
    output logic [OFF_W-1:0]  m_grant_offset,
    output logic [LEN_W-1:0]  m_grant_bytes,
    output logic              m_merged_any,
    output logic [LEN_W-1:0]  m_used_total
);

    localparam logic [BS_W-1:0] HDR_RND = round_pow2(BS_W'(HEADER_BYTES));

    logic [OFF_W-1:0] mem_s [MAX_FREE_BLOCKS];
    logic [LEN_W-1:0] mem_l [MAX_FREE_BLOCKS];

    logic [OFF_W-1:0] rd_s_reg;
    logic [LEN_W-1:0] rd_l_reg;
    logic [LOG_W-1:0] log_reg, log_next;
    logic [LEN_W-1:0] used_reg, used_next;
    logic [OP_W-1:0]  op_reg;
    logic [OFF_W-1:0] boff_reg;
    logic [LEN_W-1:0] bbytes_reg;
    logic [BS_W-1:0]  bs_reg;
    logic [OFF_W-1:0] key_s_reg, cur_s_reg;
    logic [LEN_W-1:0] key_l_reg, cur_l_reg;
    logic [ST_W-1:0]  st_reg;
    logic [OFF_W-1:0] goff_reg;
    logic [LEN_W-1:0] gbytes_reg;
    logic             merged_reg;
    logic [ST_W-1:0]  m_status_reg;
    logic [OFF_W-1:0] m_goff_reg;
    logic [LEN_W-1:0] m_gbytes_reg;
    logic             m_merged_reg;
    logic [LEN_W-1:0] m_used_reg;

    logic [LEN_W-1:0] al_excess, al_bs_eff, sh_excess, app_len, take_n;
    logic [OFF_W-1:0] app_start;
    logic [OFF_W-1:0] w_s;
    logic [LEN_W-1:0] w_l;
    logic [LEN_W:0]   end_sum, join_sum;
    logic [LOG_W-1:0] cfg_clamped;

    always_comb begin
        al_excess = rd_l_reg - bs_reg[LEN_W-1:0];
        al_bs_eff = ({2'b00, al_excess} <= HDR_RND) ? rd_l_reg : bs_reg[LEN_W-1:0];
        sh_excess = bbytes_reg - bs_reg[LEN_W-1:0];
        end_sum   = {1'b0, OFF_W'(0), 1'b0} + {2'b00, cur_s_reg} + {1'b0, cur_l_reg};
        join_sum  = {1'b0, cur_l_reg} + {1'b0, rd_l_reg};
        if (op_reg == OP_FREE) begin
            app_start = boff_reg;
            app_len   = bbytes_reg;
        end else begin
            app_start = boff_reg + bs_reg[OFF_W-1:0];
            app_len   = sh_excess;
        end
        take_n = app_len;
        sts.fit        = {2'b00, rd_l_reg} >= bs_reg;
        sts.empties    = {2'b00, al_excess} <= HDR_RND;
        sts.key_gt     = rd_s_reg > key_s_reg;
        sts.adj        = end_sum == {2'b00, rd_s_reg};
        sts.free_zero  = bbytes_reg == '0;
        sts.shr_grow   = bs_reg > {2'b00, bbytes_reg};
        sts.shr_append = (bs_reg <= {2'b00, bbytes_reg}) && ({2'b00, sh_excess} > HDR_RND);
        sts.op         = op_reg;
        case (cmd.wsel)
            WS_INIT: begin
                w_s = '0;
                w_l = LEN_W'(1) << log_reg;
            end
            WS_ALLOC: begin
                w_s = rd_s_reg + al_bs_eff[OFF_W-1:0];
                w_l = rd_l_reg - al_bs_eff;
            end
            WS_RD: begin
                w_s = rd_s_reg;
                w_l = rd_l_reg;
            end
            WS_APPEND: begin
                w_s = app_start;
                w_l = app_len;
            end
            WS_KEY: begin
                w_s = key_s_reg;
                w_l = key_l_reg;
            end
            default: begin
                w_s = cur_s_reg;
                w_l = cur_l_reg;
            end
        endcase
        if (cfg_wdata < LOG_W'(6)) begin
            cfg_clamped = LOG_W'(6);
        end else if ({27'd0, cfg_wdata} > MAX_HEAP_LOG2) begin
            cfg_clamped = LOG_W'(MAX_HEAP_LOG2);
        end else begin
            cfg_clamped = cfg_wdata;
        end
        log_next  = cmd.cfg_load ? cfg_clamped : log_reg;
        used_next = used_reg;
        if (cmd.init_wr) begin
            used_next = '0;
        end else if (cmd.alloc_take) begin
            used_next = used_reg + al_bs_eff;
        end else if (cmd.append) begin
            used_next = (take_n >= used_reg) ? '0 : used_reg - take_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.we) begin
            mem_s[wr_addr] <= w_s;
            mem_l[wr_addr] <= w_l;
        end
        rd_s_reg <= mem_s[rd_addr];
        rd_l_reg <= mem_l[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_reg  <= LOG_W'(16);
            used_reg <= '0;
        end else begin
            log_reg  <= log_next;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg     <= s_opcode;
            boff_reg   <= s_block_offset;
            bbytes_reg <= s_block_bytes;
            bs_reg     <= round_pow2(BS_W'(HEADER_BYTES) + BS_W'(s_req_size));
            st_reg     <= (s_opcode == OP_ALLOC) ? ST_NOFIT : ST_OK;
            merged_reg <= 1'b0;
            if (s_opcode == OP_SHRINK) begin
                goff_reg   <= s_block_offset;
                gbytes_reg <= s_block_bytes;
            end else begin
                goff_reg   <= '0;
                gbytes_reg <= '0;
            end
        end
        if (cmd.status_wr) begin
            st_reg <= cmd.status_val;
        end
        if (cmd.alloc_take) begin
            goff_reg   <= rd_s_reg;
            gbytes_reg <= al_bs_eff;
        end
        if (cmd.append && op_reg == OP_SHRINK) begin
            gbytes_reg <= bs_reg[LEN_W-1:0];
        end
        if (cmd.key_load) begin
            key_s_reg <= rd_s_reg;
            key_l_reg <= rd_l_reg;
        end
        if (cmd.cur_load) begin
            cur_s_reg <= rd_s_reg;
            cur_l_reg <= rd_l_reg;
        end else if (cmd.cur_join) begin
            cur_l_reg  <= join_sum[LEN_W] ? {LEN_W{1'b1}} : join_sum[LEN_W-1:0];
            merged_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            m_status_reg <= st_reg;
            m_goff_reg   <= goff_reg;
            m_gbytes_reg <= gbytes_reg;
            m_merged_reg <= merged_reg;
            m_used_reg   <= used_reg;
        end
    end

    assign m_status       = m_status_reg;
    assign m_grant_offset = m_goff_reg;
    assign m_grant_bytes  = m_gbytes_reg;
    assign m_merged_any   = m_merged_reg;
    assign m_used_total   = m_used_reg;

endmodule

@@ src/ffba_ctrl.sv @@
// Controller of the allocator: sequencer state, table indices and handshakes.
`timescale 1ns / 1ps
module ffba_ctrl import ffba_pkg::*; #(
    parameter int MAX_FREE_BLOCKS = 64,
    localparam int IDX_W = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1,
    localparam int CNT_W = $clog2(MAX_FREE_BLOCKS + 1) + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  ffba_sts_t        sts,
    output ffba_cmd_t        cmd,
    output logic [IDX_W-1:0] rd_addr,
    output logic [IDX_W-1:0] wr_addr
);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_EXEC     = 4'd2;
    localparam logic [3:0] S_AL_RD    = 4'd3;
    localparam logic [3:0] S_AL_CHK   = 4'd4;
    localparam logic [3:0] S_SH_RD    = 4'd5;
    localparam logic [3:0] S_SH_WR    = 4'd6;
    localparam logic [3:0] S_SO_I     = 4'd7;
    localparam logic [3:0] S_SO_KEY   = 4'd8;
    localparam logic [3:0] S_SO_RD    = 4'd9;
    localparam logic [3:0] S_SO_CMP   = 4'd10;
    localparam logic [3:0] S_MG_START = 4'd11;
    localparam logic [3:0] S_MG_LD    = 4'd12;
    localparam logic [3:0] S_MG_RD    = 4'd13;
    localparam logic [3:0] S_MG_CMP   = 4'd14;
    localparam logic [3:0] S_FIN      = 4'd15;

    localparam logic [CNT_W-1:0] MAXN = CNT_W'(MAX_FREE_BLOCKS);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next, i_reg, i_next, j_reg, j_next;
    logic [CNT_W-1:0] rd_idx, wr_idx, j_plus, j_minus;
    logic             m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        rd_idx     = i_reg;
        wr_idx     = j_reg;
        j_plus     = j_reg + ONE;
        j_minus    = j_reg - ONE;
        s_ready    = (state_reg == S_IDLE) && !cfg_valid;
        cfg_ready  = state_reg == S_IDLE;
        case (state_reg)
            S_INIT: begin
                cmd.we      = 1'b1;
                cmd.wsel    = WS_INIT;
                cmd.init_wr = 1'b1;
                wr_idx      = '0;
                n_next      = ONE;
                state_next  = S_IDLE;
            end
            S_IDLE: begin
                if (cfg_valid) begin
                    cmd.cfg_load = 1'b1;
                    state_next   = S_INIT;
                end else if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FIN;
                case (sts.op)
                    OP_ALLOC: begin
                        i_next     = '0;
                        state_next = S_AL_RD;
                    end
                    OP_MERGE: begin
                        i_next = ONE;
                        if (n_reg != '0) begin
                            state_next = S_SO_I;
                        end
                    end
                    default: begin
                        if (sts.op == OP_SHRINK && sts.shr_grow) begin
                            cmd.status_wr  = 1'b1;
                            cmd.status_val = ST_GROW;
                        end else if ((sts.op == OP_FREE && !sts.free_zero) ||
                                     (sts.op == OP_SHRINK && sts.shr_append)) begin
                            if (n_reg >= MAXN) begin
                                cmd.status_wr  = 1'b1;
                                cmd.status_val = ST_FULL;
                            end else begin
                                cmd.we     = 1'b1;
                                cmd.wsel   = WS_APPEND;
                                cmd.append = 1'b1;
                                wr_idx     = n_reg;
                                n_next     = n_reg + ONE;
                            end
                        end
                    end
                endcase
            end
            S_AL_RD: begin
                if (i_reg >= n_reg) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_AL_CHK;
                end
            end
            S_AL_CHK: begin
                if (sts.fit) begin
                    cmd.we         = 1'b1;
                    cmd.wsel       = WS_ALLOC;
                    cmd.alloc_take = 1'b1;
                    cmd.status_wr  = 1'b1;
                    cmd.status_val = ST_OK;
                    wr_idx         = i_reg;
                    j_next         = i_reg;
                    state_next     = sts.empties ? S_SH_RD : S_FIN;
                end else begin
                    i_next     = i_reg + ONE;
                    state_next = S_AL_RD;
                end
            end
            S_SH_RD: begin
                rd_idx = j_plus;
                if (j_plus >= n_reg) begin
                    n_next     = n_reg - ONE;
                    state_next = S_FIN;
                end else begin
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR: begin
                cmd.we     = 1'b1;
                cmd.wsel   = WS_RD;
                j_next     = j_plus;
                state_next = S_SH_RD;
            end
            S_SO_I: begin
                if (i_reg >= n_reg) begin
                    state_next = S_MG_START;
                end else begin
                    state_next = S_SO_KEY;
                end
            end
            S_SO_KEY: begin
                cmd.key_load = 1'b1;
                j_next       = i_reg;
                state_next   = S_SO_RD;
            end
            S_SO_RD: begin
                rd_idx = j_minus;
                if (j_reg == '0) begin
                    cmd.we     = 1'b1;
                    cmd.wsel   = WS_KEY;
                    i_next     = i_reg + ONE;
                    state_next = S_SO_I;
                end else begin
                    state_next = S_SO_CMP;
                end
            end
            S_SO_CMP: begin
                cmd.we = 1'b1;
                if (sts.key_gt) begin
                    cmd.wsel   = WS_RD;
                    j_next     = j_minus;
                    state_next = S_SO_RD;
                end else begin
                    cmd.wsel   = WS_KEY;
                    i_next     = i_reg + ONE;
                    state_next = S_SO_I;
                end
            end
            S_MG_START: begin
                rd_idx     = '0;
                state_next = S_MG_LD;
            end
            S_MG_LD: begin
                cmd.cur_load = 1'b1;
                i_next       = ONE;
                j_next       = '0;
                state_next   = S_MG_RD;
            end
            S_MG_RD: begin
                if (i_reg >= n_reg) begin
                    cmd.we     = 1'b1;
                    cmd.wsel   = WS_CUR;
                    n_next     = j_plus;
                    state_next = S_FIN;
                end else begin
                    state_next = S_MG_CMP;
                end
            end
            S_MG_CMP: begin
                if (sts.adj) begin
                    cmd.cur_join = 1'b1;
                end else begin
                    cmd.we       = 1'b1;
                    cmd.wsel     = WS_CUR;
                    cmd.cur_load = 1'b1;
                    j_next       = j_plus;
                end
                i_next     = i_reg + ONE;
                state_next = S_MG_RD;
            end
            default: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
        rd_addr      = rd_idx[IDX_W-1:0];
        wr_addr      = wr_idx[IDX_W-1:0];
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            n_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= MAXN) else $error("free table count beyond its depth");
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid) else $error("loaded result not presented");
    a_cfg_reinit: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> state_reg == S_INIT)
        else $error("configuration write did not reinitialise the table");
    a_append_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.append |-> n_reg < MAXN) else $error("append into a full table");

endmodule

@@ src/first_fit_block_allocator.sv @@
// Top level of the first-fit block allocator: controller and datapath.
//
//  channel | direction | ports
//  s_      | in        | s_valid, s_ready, s_opcode, s_req_size, s_block_offset, s_block_bytes
//  m_      | out       | m_valid, m_ready, m_status, m_grant_offset, m_grant_bytes, ...
//  cfg_    | in        | cfg_valid, cfg_ready, cfg_wdata (heap_log2)
//
// Free and shrink append at most one free entry; alloc scans the table for the first
// entry that fits and moves the later entries down when a block empties; merge sorts
// the n free entries by offset, then sweeps them and joins adjacent ones.
// After reset and each configuration write, the table is rebuilt as one free block.
// A stalled result waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
module first_fit_block_allocator import ffba_pkg::*; #(
    parameter int MAX_FREE_BLOCKS = 64,
    parameter int HEADER_BYTES    = 32,
    parameter int MAX_HEAP_LOG2   = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [OP_W-1:0]  s_opcode,
    input  logic [LEN_W-1:0] s_req_size,
    input  logic [OFF_W-1:0] s_block_offset,
    input  logic [LEN_W-1:0] s_block_bytes,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ST_W-1:0]  m_status,
    output logic [OFF_W-1:0] m_grant_offset,
    output logic [LEN_W-1:0] m_grant_bytes,
    output logic             m_merged_any,
    output logic [LEN_W-1:0] m_used_total,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LOG_W-1:0] cfg_wdata
);

    localparam int IDX_W = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;

    ffba_cmd_t        cmd;
    ffba_sts_t        sts;
    logic [IDX_W-1:0] rd_addr, wr_addr;

    ffba_ctrl #(
        .MAX_FREE_BLOCKS(MAX_FREE_BLOCKS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    ffba_dp #(
        .MAX_FREE_BLOCKS(MAX_FREE_BLOCKS),
        .HEADER_BYTES   (HEADER_BYTES),
        .MAX_HEAP_LOG2  (MAX_HEAP_LOG2)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .cfg_wdata     (cfg_wdata),
        .s_opcode      (s_opcode),
        .s_req_size    (s_req_size),
        .s_block_offset(s_block_offset),
        .s_block_bytes (s_block_bytes),
        .m_status      (m_status),
        .m_grant_offset(m_grant_offset),
        .m_grant_bytes (m_grant_bytes),
        .m_merged_any  (m_merged_any),
        .m_used_total  (m_used_total)
    );

endmodule
